@@ sv/ssq_pkg.sv @@
// Shared types and constants of the synthetic spread quote block.
// No dependencies; every other file refers to it by scoped names.
package ssq_pkg;

   localparam int PRICE_W    = 48;
   localparam int WEIGHT_W   = 24;
   localparam int QTY_W      = 32;
   localparam int SUM_W      = 64;
   localparam int LANE_W     = 24;
   localparam int REQ_DATA_W = 232;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 256;
   localparam int RSP_USER_W = 2;

   typedef logic signed [PRICE_W-1:0]  price_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic [QTY_W-1:0]           qty_type;
   typedef logic [SUM_W-1:0]           sum_type;

   // One book level of a leg, already routed to the synthetic side it feeds.
   typedef struct packed {
      logic      present;
      price_type price;
      qty_type   qty;
   } level_type;

   // Classified leg as it sits in the queue.
   typedef struct packed {
      price_type  price;
      weight_type weight;
      level_type  bid;
      level_type  ask;
      logic       final_leg;
   } leg_type;

   // Size and control that ride along the multiply stages.
   typedef struct packed {
      logic    bid_present;
      qty_type bid_qty;
      logic    ask_present;
      qty_type ask_qty;
      logic    final_leg;
   } leg_meta_type;

endpackage

@@ sv/ssq_front.sv @@
// Front end: unpacks a leg beat and routes its bid and ask levels to the
// synthetic sides by the sign of the weight. Depends on ssq_pkg.
module ssq_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // leg_price, leg_weight, bid_price, bid_qty, ask_price, ask_qty
   input  logic [ssq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // bid_present, ask_present
   input  logic [ssq_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tlast,
   output logic                            push_valid,
   input  logic                            push_ready,
   output ssq_pkg::leg_type                push_data
);

   ssq_pkg::level_type bid_level;
   ssq_pkg::level_type ask_level;
   ssq_pkg::weight_type weight;
   logic                positive;

   assign weight = req_tdata[71:48];

   assign bid_level.present = req_tuser[0];
   assign bid_level.price   = req_tdata[119:72];
   assign bid_level.qty     = req_tdata[151:120];
   assign ask_level.present = req_tuser[1];
   assign ask_level.price   = req_tdata[199:152];
   assign ask_level.qty     = req_tdata[231:200];

   // zero weight counts as negative: sides swap
   assign positive = !weight[ssq_pkg::WEIGHT_W-1] && (weight != '0);

   always_comb begin
      push_data.price     = req_tdata[47:0];
      push_data.weight    = weight;
      push_data.bid       = positive ? bid_level : ask_level;
      push_data.ask       = positive ? ask_level : bid_level;
      push_data.final_leg = req_tlast;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

@@ sv/ssq_queue.sv @@
// Short FIFO of classified legs between front and back ends.
// Depends on ssq_pkg for the entry type.
module ssq_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ssq_pkg::leg_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ssq_pkg::leg_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ssq_pkg::leg_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (count_ff == '0 || count_ff == CNT_W'(DEPTH)))
      else $error("queue pointers disagree with fill count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");

endmodule

@@ sv/ssq_wmul.sv @@
// Weighted price lane: floor(price * weight / 2^FRAC_BITS), two stages.
// The 48 bit price is split into 24 bit halves. Depends on ssq_pkg.
module ssq_wmul #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                en,
   input  ssq_pkg::price_type  price,
   input  ssq_pkg::weight_type weight,
   output ssq_pkg::sum_type    contrib
);

   localparam int LO_W   = ssq_pkg::LANE_W + 1 + ssq_pkg::WEIGHT_W;
   localparam int HI_W   = ssq_pkg::PRICE_W - ssq_pkg::LANE_W + ssq_pkg::WEIGHT_W;
   localparam int FULL_W = ssq_pkg::PRICE_W + ssq_pkg::WEIGHT_W;

   logic signed [ssq_pkg::LANE_W:0]   price_lo;
   logic signed [ssq_pkg::LANE_W-1:0] price_hi;
   logic signed [LO_W-1:0]            lo_ff, lo_in;
   logic signed [HI_W-1:0]            hi_ff, hi_in;
   logic signed [FULL_W-1:0]          full;
   logic signed [FULL_W-1:0]          shifted;
   ssq_pkg::sum_type                  contrib_ff;

   assign price_lo = {1'b0, price[ssq_pkg::LANE_W-1:0]};
   assign price_hi = price[ssq_pkg::PRICE_W-1:ssq_pkg::LANE_W];
   assign lo_in    = price_lo * weight;
   assign hi_in    = price_hi * weight;

   assign full = {{(FULL_W - HI_W - ssq_pkg::LANE_W){hi_ff[HI_W-1]}}, hi_ff,
                  {ssq_pkg::LANE_W{1'b0}}}
               + {{(FULL_W - LO_W){lo_ff[LO_W-1]}}, lo_ff};
   // arithmetic shift rounds toward minus infinity
   assign shifted = full >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         contrib_ff <= shifted[ssq_pkg::SUM_W-1:0];
      end
   end

   assign contrib = contrib_ff;

endmodule

@@ sv/ssq_back.sv @@
// Back end: three weighted multiply lanes, the running sums and minimum
// sizes, and the quote output register. Depends on ssq_pkg and ssq_wmul.
module ssq_back #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  ssq_pkg::leg_type               pop_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ssq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [ssq_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic                  en;
   logic                  p_vld_ff, c_vld_ff;
   ssq_pkg::leg_meta_type p_meta_ff, c_meta_ff, meta_in;
   ssq_pkg::sum_type      price_contrib, bid_contrib, ask_contrib;

   ssq_pkg::sum_type price_sum_ff, price_sum_in, price_sum_upd;
   ssq_pkg::sum_type bid_sum_ff, bid_sum_in, bid_sum_upd;
   ssq_pkg::sum_type ask_sum_ff, ask_sum_in, ask_sum_upd;
   ssq_pkg::qty_type bid_min_ff, bid_min_in, bid_min_upd;
   ssq_pkg::qty_type ask_min_ff, ask_min_in, ask_min_upd;

   logic             rsp_vld_ff, rsp_vld_in;
   ssq_pkg::sum_type rsp_price_ff, rsp_bid_ff, rsp_ask_ff;
   ssq_pkg::qty_type rsp_bid_qty_ff, rsp_ask_qty_ff;
   logic             rsp_bid_valid_ff, rsp_ask_valid_ff;
   logic             accum, emit, bid_ok, ask_ok;

   // stall the lanes only while a finished quote waits and another is due
   assign en        = !(c_vld_ff && c_meta_ff.final_leg && rsp_vld_ff && !rsp_tready);
   assign pop_ready = en;
   assign accum     = en && c_vld_ff;
   assign emit      = accum && c_meta_ff.final_leg;

   always_comb begin
      meta_in.bid_present = pop_data.bid.present;
      meta_in.bid_qty     = pop_data.bid.qty;
      meta_in.ask_present = pop_data.ask.present;
      meta_in.ask_qty     = pop_data.ask.qty;
      meta_in.final_leg   = pop_data.final_leg;
   end

   ssq_wmul #(.FRAC_BITS(WEIGHT_FRAC_BITS)) u_price_lane (
      .clock(clock), .en(en), .price(pop_data.price), .weight(pop_data.weight),
      .contrib(price_contrib)
   );

   ssq_wmul #(.FRAC_BITS(WEIGHT_FRAC_BITS)) u_bid_lane (
      .clock(clock), .en(en), .price(pop_data.bid.price), .weight(pop_data.weight),
      .contrib(bid_contrib)
   );

   ssq_wmul #(.FRAC_BITS(WEIGHT_FRAC_BITS)) u_ask_lane (
      .clock(clock), .en(en), .price(pop_data.ask.price), .weight(pop_data.weight),
      .contrib(ask_contrib)
   );

   always_comb begin
      price_sum_upd = price_sum_ff + price_contrib;
      if (!c_meta_ff.bid_present) begin
         bid_sum_upd = '0;
         bid_min_upd = '0;
      end else begin
         bid_sum_upd = bid_sum_ff + bid_contrib;
         bid_min_upd = (c_meta_ff.bid_qty < bid_min_ff) ? c_meta_ff.bid_qty : bid_min_ff;
      end
      if (!c_meta_ff.ask_present) begin
         ask_sum_upd = '0;
         ask_min_upd = '0;
      end else begin
         ask_sum_upd = ask_sum_ff + ask_contrib;
         ask_min_upd = (c_meta_ff.ask_qty < ask_min_ff) ? c_meta_ff.ask_qty : ask_min_ff;
      end
      bid_ok = bid_min_upd != '0;
      ask_ok = ask_min_upd != '0;

      price_sum_in = price_sum_ff;
      bid_sum_in   = bid_sum_ff;
      ask_sum_in   = ask_sum_ff;
      bid_min_in   = bid_min_ff;
      ask_min_in   = ask_min_ff;
      if (emit) begin
         // quote goes out, sums start over
         price_sum_in = '0;
         bid_sum_in   = '0;
         ask_sum_in   = '0;
         bid_min_in   = '1;
         ask_min_in   = '1;
      end else if (accum) begin
         price_sum_in = price_sum_upd;
         bid_sum_in   = bid_sum_upd;
         ask_sum_in   = ask_sum_upd;
         bid_min_in   = bid_min_upd;
         ask_min_in   = ask_min_upd;
      end

      priority if (emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         price_sum_ff <= '0;
         bid_sum_ff   <= '0;
         ask_sum_ff   <= '0;
         bid_min_ff   <= '1;
         ask_min_ff   <= '1;
      end else begin
         if (en) begin
            p_vld_ff <= pop_valid;
            c_vld_ff <= p_vld_ff;
         end
         rsp_vld_ff   <= rsp_vld_in;
         price_sum_ff <= price_sum_in;
         bid_sum_ff   <= bid_sum_in;
         ask_sum_ff   <= ask_sum_in;
         bid_min_ff   <= bid_min_in;
         ask_min_ff   <= ask_min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_meta_ff <= meta_in;
         c_meta_ff <= p_meta_ff;
      end
      if (emit) begin
         rsp_price_ff     <= price_sum_upd;
         rsp_bid_valid_ff <= bid_ok;
         rsp_bid_ff       <= bid_ok ? bid_sum_upd : '0;
         rsp_bid_qty_ff   <= bid_ok ? bid_min_upd : '0;
         rsp_ask_valid_ff <= ask_ok;
         rsp_ask_ff       <= ask_ok ? ask_sum_upd : '0;
         rsp_ask_qty_ff   <= ask_ok ? ask_min_upd : '0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_ask_qty_ff, rsp_ask_ff, rsp_bid_qty_ff, rsp_bid_ff, rsp_price_ff};
   assign rsp_tuser  = {rsp_ask_valid_ff, rsp_bid_valid_ff};

   a_restart: assert property (@(posedge clock) disable iff (reset)
      emit |=> (bid_min_ff == '1 && ask_min_ff == '1 && price_sum_ff == '0))
      else $error("accumulators not restarted after final leg");

   a_bid_side: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_bid_valid_ff == (rsp_bid_qty_ff != '0)
                      && (rsp_bid_valid_ff || rsp_bid_ff == '0)))
      else $error("bid side of quote inconsistent");

   a_ask_side: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ask_valid_ff == (rsp_ask_qty_ff != '0)
                      && (rsp_ask_valid_ff || rsp_ask_ff == '0)))
      else $error("ask side of quote inconsistent");

endmodule

@@ sv/synthetic_spread_quote.sv @@
// Synthetic spread quote: folds legs in at one beat per cycle while not stalled.
// A final leg's quote shows on rsp_tvalid after the queue entry, the multiply
// lane stages and the combine and accumulate step. The lanes stall only when
// a second quote is due while the first still waits at the output register.
// Synchronous reset empties the queue and lanes and restores the accumulators.
module synthetic_spread_quote #(
   parameter int WEIGHT_FRAC_BITS = 16,
   parameter int QUEUE_DEPTH      = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // leg_price, leg_weight, bid_price, bid_qty, ask_price, ask_qty
   input  logic [ssq_pkg::REQ_DATA_W-1:0] req_tdata,
   // bid_present, ask_present
   input  logic [ssq_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // synth_price, synth_bid, synth_bid_qty, synth_ask, synth_ask_qty
   output logic [ssq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bid_valid, ask_valid
   output logic [ssq_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic             push_valid, push_ready, pop_valid, pop_ready;
   ssq_pkg::leg_type push_data, pop_data;

   ssq_front u_front (
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   ssq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   ssq_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule
